[src/lkvc_pkg.sv]
// Shared types and constants for the LRU key/value cache core.
// Used by every module of the block; depends on nothing else.
package lkvc_pkg;

    localparam int ENTRIES    = 128;
    localparam int KEY_BITS   = 64;
    localparam int DATA_BITS  = 32;
    localparam int GROUP_SIZE = 16;
    localparam int NGROUPS    = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);
    localparam int CMP_BITS   = (CNT_BITS > 8) ? CNT_BITS : 8;

    localparam logic [7:0] CAP_RESET = 8'd100;

    localparam logic [1:0] REQ_GET    = 2'd0;
    localparam logic [1:0] REQ_PUT    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] data;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER,
        CELL_CLEAR
    } t_cell_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_RED1,
        ST_RED2,
        ST_UPD
    } t_state;

endpackage

[src/lkvc_cell.sv]
// One cell of the recency chain: holds one entry and compares its key.
// Depends on lkvc_pkg.
module lkvc_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lkvc_pkg::t_cell_op                i_op,
    input  lkvc_pkg::t_entry                  i_lower,
    input  lkvc_pkg::t_entry                  i_upper,
    input  logic [lkvc_pkg::KEY_BITS-1:0]     i_key,
    output lkvc_pkg::t_entry                  o_entry,
    output logic                              o_match
);
    import lkvc_pkg::*;

    logic                 r_valid, n_valid;
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [DATA_BITS-1:0] r_data, n_data;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_data  = r_data;
        case (i_op)
            CELL_FROM_LOWER: begin
                n_valid = i_lower.valid;
                n_key   = i_lower.key;
                n_data  = i_lower.data;
            end
            CELL_FROM_UPPER: begin
                n_valid = i_upper.valid;
                n_key   = i_upper.key;
                n_data  = i_upper.data;
            end
            CELL_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_data <= n_data;
    end

    assign o_entry = '{valid: r_valid, key: r_key, data: r_data};
    assign o_match = r_valid && (r_key == i_key);

endmodule

[src/lkvc_select_tree.sv]
// Two-stage registered OR tree that picks the matching entry's data and the
// last valid entry's key out of the chain. Depends on lkvc_pkg.
module lkvc_select_tree (
    input  logic                              i_clk,
    input  lkvc_pkg::t_entry                  i_entry [lkvc_pkg::ENTRIES],
    input  logic [lkvc_pkg::ENTRIES-1:0]      i_match,
    input  logic [lkvc_pkg::ENTRIES-1:0]      i_last,
    output logic [lkvc_pkg::DATA_BITS-1:0]    o_hit_data,
    output logic [lkvc_pkg::KEY_BITS-1:0]     o_last_key
);
    import lkvc_pkg::*;

    logic [DATA_BITS-1:0] r_grp_data [NGROUPS];
    logic [KEY_BITS-1:0]  r_grp_key  [NGROUPS];
    logic [DATA_BITS-1:0] n_data;
    logic [KEY_BITS-1:0]  n_key;
    logic [DATA_BITS-1:0] r_data;
    logic [KEY_BITS-1:0]  r_key;

    for (genvar g = 0; g < NGROUPS; g++) begin : g_grp
        localparam int LO = g * GROUP_SIZE;
        localparam int HI = ((LO + GROUP_SIZE) < ENTRIES) ? (LO + GROUP_SIZE) : ENTRIES;
        logic [DATA_BITS-1:0] n_gd;
        logic [KEY_BITS-1:0]  n_gk;

        always_comb begin
            n_gd = '0;
            n_gk = '0;
            for (int j = LO; j < HI; j++) begin
                n_gd = n_gd | (i_entry[j].data & {DATA_BITS{i_match[j]}});
                n_gk = n_gk | (i_entry[j].key & {KEY_BITS{i_last[j]}});
            end
        end

        always_ff @(posedge i_clk) begin
            r_grp_data[g] <= n_gd;
            r_grp_key[g]  <= n_gk;
        end
    end

    always_comb begin
        n_data = '0;
        n_key  = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            n_data = n_data | r_grp_data[g];
            n_key  = n_key | r_grp_key[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_key  <= n_key;
    end

    assign o_hit_data = r_data;
    assign o_last_key = r_key;

endmodule

[src/lru_key_value_cache_core.sv]
// Top level of the fully associative LRU key/value cache core.
// Depends on lkvc_pkg, lkvc_cell and lkvc_select_tree.
//
// A request is taken when start is high and busy is low. A request passes
// through these states before the next can be accepted: key compare in every
// cell of the chain (ST_CMP), the registered select tree that fetches the hit
// data and the least recent key (ST_RED1, ST_RED2), the state in which the
// chain shifts to its new recency order (ST_UPD), and then idle with busy low,
// in which the next request can be taken. The result word appears on the
// o_ result ports for exactly one cycle, marked by o_valid, in the first cycle
// in which busy is low again. It must be taken then since the receiver cannot
// stall. The capacity register may be written whenever no request is in flight.
// The store is empty right after reset with no clearing pass.
module lru_key_value_cache_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_key_tag,
    input  logic [31:0] i_data_in,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    output logic        o_hit,
    output logic [31:0] o_data_out,
    output logic        o_evicted,
    output logic [63:0] o_evicted_key,
    output logic [7:0]  o_entry_count
);
    import lkvc_pkg::*;

    t_state               r_state, n_state;
    logic [1:0]           r_req;
    logic [KEY_BITS-1:0]  r_key;
    logic [DATA_BITS-1:0] r_data;
    logic [7:0]           r_cap;
    logic [CNT_BITS-1:0]  r_count, n_count;
    logic [ENTRIES-1:0]   r_match, r_last, r_above, r_below;
    logic [ENTRIES-1:0]   w_match, w_last;
    t_entry               w_entry [ENTRIES];
    t_cell_op             w_op    [ENTRIES];
    t_entry               w_new;
    t_entry               w_none;
    logic [DATA_BITS-1:0] w_hit_data;
    logic [KEY_BITS-1:0]  w_last_key;
    logic [CMP_BITS-1:0]  w_cap_eff;
    logic                 w_accept, w_upd, w_any_hit, w_evict;
    logic                 n_hit, n_evicted;
    logic [DATA_BITS-1:0] n_dout;
    logic [KEY_BITS-1:0]  n_evkey;
    logic                 r_valid, r_hit, r_evicted;
    logic [31:0]          r_dout;
    logic [63:0]          r_evkey;
    logic [7:0]           r_ecount;

    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_CMP;
            ST_CMP:  n_state = ST_RED1;
            ST_RED1: n_state = ST_RED2;
            ST_RED2: n_state = ST_UPD;
            ST_UPD:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy  = 1'b1;
        w_upd = 1'b0;
        case (r_state)
            ST_IDLE: busy  = 1'b0;
            ST_UPD:  w_upd = 1'b1;
            default: busy  = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cap   <= CAP_RESET;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_upd;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (w_upd) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_req_type;
            r_key  <= KEY_BITS'(i_key_tag);
            r_data <= DATA_BITS'(i_data_in);
        end
        if (r_state == ST_CMP) begin
            r_match <= w_match;
            r_last  <= w_last;
        end
        if (w_upd) begin
            r_hit     <= n_hit;
            r_dout    <= 32'(n_dout);
            r_evicted <= n_evicted;
            r_evkey   <= 64'(n_evkey);
            r_ecount  <= 8'(n_count);
        end
    end

    for (genvar i = 0; i < ENTRIES; i++) begin : g_vec
        if (i == ENTRIES - 1) begin : g_top
            assign w_last[i] = w_entry[i].valid;
        end else begin : g_mid
            assign w_last[i] = w_entry[i].valid && !w_entry[i+1].valid;
        end
        always_ff @(posedge i_clk) begin
            r_above[i] <= |(r_match >> i);
            r_below[i] <= |(r_match << (ENTRIES - 1 - i));
        end
    end

    always_comb begin
        w_cap_eff = CMP_BITS'(r_cap);
        if (r_cap == 8'd0) begin
            w_cap_eff = CMP_BITS'(1);
        end else if (CMP_BITS'(r_cap) > CMP_BITS'(ENTRIES)) begin
            w_cap_eff = CMP_BITS'(ENTRIES);
        end
    end

    always_comb begin
        w_any_hit = |r_match;
        w_evict   = (r_req == REQ_PUT) && !w_any_hit
                    && (CMP_BITS'(r_count) >= w_cap_eff);
        n_hit     = 1'b0;
        n_dout    = '0;
        n_evicted = 1'b0;
        n_evkey   = '0;
        n_count   = r_count;
        case (r_req)
            REQ_GET: begin
                n_hit  = w_any_hit;
                n_dout = w_any_hit ? w_hit_data : '0;
            end
            REQ_PUT: begin
                n_hit = w_any_hit;
                if (!w_any_hit) begin
                    n_evicted = w_evict;
                    n_evkey   = w_evict ? w_last_key : '0;
                    n_count   = w_evict ? r_count : r_count + CNT_BITS'(1);
                end
            end
            REQ_REMOVE: begin
                n_hit   = w_any_hit;
                n_count = w_any_hit ? r_count - CNT_BITS'(1) : r_count;
            end
            default: begin
                n_hit = 1'b0;
            end
        endcase
    end

    assign w_new.valid = 1'b1;
    assign w_new.key   = r_key;
    assign w_new.data  = (r_req == REQ_PUT) ? r_data : w_hit_data;
    assign w_none      = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        t_entry w_lower, w_upper;
        logic   w_prev_last;

        if (i == 0) begin : g_first
            assign w_lower     = w_new;
            assign w_prev_last = 1'b0;
        end else begin : g_rest
            assign w_lower     = w_entry[i-1];
            assign w_prev_last = r_last[i-1];
        end
        if (i == ENTRIES - 1) begin : g_end
            assign w_upper = w_none;
        end else begin : g_inner
            assign w_upper = w_entry[i+1];
        end

        always_comb begin
            w_op[i] = CELL_HOLD;
            if (w_upd) begin
                case (r_req)
                    REQ_GET: begin
                        if (r_above[i]) w_op[i] = CELL_FROM_LOWER;
                    end
                    REQ_PUT: begin
                        if (w_any_hit) begin
                            if (r_above[i]) w_op[i] = CELL_FROM_LOWER;
                        end else if (w_evict && w_prev_last) begin
                            w_op[i] = CELL_CLEAR;
                        end else begin
                            w_op[i] = CELL_FROM_LOWER;
                        end
                    end
                    REQ_REMOVE: begin
                        if (r_below[i]) w_op[i] = CELL_FROM_UPPER;
                    end
                    default: begin
                        w_op[i] = CELL_HOLD;
                    end
                endcase
            end
        end

        lkvc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op[i]),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .i_key   (r_key),
            .o_entry (w_entry[i]),
            .o_match (w_match[i])
        );
    end

    lkvc_select_tree u_tree (
        .i_clk      (i_clk),
        .i_entry    (w_entry),
        .i_match    (r_match),
        .i_last     (r_last),
        .o_hit_data (w_hit_data),
        .o_last_key (w_last_key)
    );

    assign o_valid       = r_valid;
    assign o_hit         = r_hit;
    assign o_data_out    = r_dout;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evkey;
    assign o_entry_count = r_ecount;

endmodule

[src/lkvc_checker.sv]
// Port-level checks for the LRU key/value cache core, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache_core.
module lkvc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic       o_hit,
    input logic       o_evicted,
    input logic [7:0] o_entry_count
);
    import lkvc_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("Busy did not rise after an accepted request.");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("Result strobe lasted more than one cycle.");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("Result word appeared without a request finishing.");

    a_evict_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evicted |-> !o_hit && (o_entry_count != 8'd0))
        else $error("Eviction reported on a hit or with an empty store.");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (.*);
